>>> hdl/ppc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_pkg: planar pose composition shared definitions
// widths, fixed-point constants, the arctangent table, command codes,
// the sideband carried beside the rotator and the yaw wrap / saturate helpers
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int POS_WIDTH     = 32;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;

  // guard fraction bits added to positions inside the rotator
  localparam int GUARD_BITS = 8;
  // translation difference width
  localparam int VEC_W      = POS_WIDTH + 1;
  // rotator datapath: guard bits, quarter-turn negation and cordic growth
  localparam int XW         = VEC_W + GUARD_BITS + 3;
  // angle accumulator in 2^-30 rad
  localparam int ZW         = 35;
  localparam int ZSHIFT     = 33 - ANGLE_WIDTH;
  // rotated result after gain correction
  localparam int RW         = XW - GUARD_BITS;
  // final sum before saturation
  localparam int FW         = RW + 1;

  // inverse cordic gain, scaled by 2^30
  localparam int                INV_W      = 30;
  localparam logic [INV_W-1:0]  INV_GAIN   = 30'd652032874;
  localparam int                GAIN_SHIFT = INV_W + GUARD_BITS;
  localparam int                LO_W       = (XW > 32) ? 32 : XW - 1;
  localparam int                SUM_W      = XW + INV_W + 1;

  localparam longint PI_SHL29      = 64'sd1686629713;
  localparam longint HALF_PI_RAD30 = 64'sd1686629713;
  localparam longint PI_Q          =
      (PI_SHL29 + (longint'(1) << (31 - ANGLE_WIDTH))) >>> (32 - ANGLE_WIDTH);
  localparam int     YAW_EXT_W     = ANGLE_WIDTH + 2;

  // atan(2^-i) in 2^-30 rad, truncated
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [1:0] {
    CMD_COMPOSE  = 2'd0,
    CMD_RELATIVE = 2'd1,
    CMD_DIFF     = 2'd2
  } cmd_e;

  // work that bypasses the rotator
  typedef struct packed {
    logic                   use_rot;
    logic [VEC_W-1:0]       add_x;
    logic [VEC_W-1:0]       add_y;
    logic [VEC_W-1:0]       z;
    logic [ANGLE_WIDTH-1:0] yaw;
  } sb_t;

  // one 2pi correction into (-pi, pi]
  function automatic logic [ANGLE_WIDTH-1:0] wrap_yaw(input logic signed [YAW_EXT_W-1:0] a);
    logic signed [YAW_EXT_W-1:0] pi_q;
    logic signed [YAW_EXT_W-1:0] two_pi;
    logic signed [YAW_EXT_W-1:0] r;
    pi_q   = YAW_EXT_W'(PI_Q);
    two_pi = YAW_EXT_W'(2 * PI_Q);
    priority if (a <= -pi_q) begin
      r = a + two_pi;
    end else if (a > pi_q) begin
      r = a - two_pi;
    end else begin
      r = a;
    end
    return r[ANGLE_WIDTH-1:0];
  endfunction

  // {clipped, value}
  function automatic logic [POS_WIDTH:0] sat_pos(input logic signed [FW-1:0] v);
    logic signed [FW-1:0] hi_lim;
    logic signed [FW-1:0] lo_lim;
    logic [POS_WIDTH:0]   r;
    hi_lim = FW'((longint'(1) << (POS_WIDTH - 1)) - 1);
    lo_lim = FW'(-(longint'(1) << (POS_WIDTH - 1)));
    priority if (v > hi_lim) begin
      r = {1'b1, hi_lim[POS_WIDTH-1:0]};
    end else if (v < lo_lim) begin
      r = {1'b1, lo_lim[POS_WIDTH-1:0]};
    end else begin
      r = {1'b0, v[POS_WIDTH-1:0]};
    end
    return r;
  endfunction

endpackage

>>> hdl/ppc_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_prep: command decode stage
// picks the vector and angle for the rotator and works out z, yaw and addends
// ----------------------------------------------------------------------------
module ppc_prep import ppc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [1:0]                    command_i,
  input  logic signed [POS_WIDTH-1:0]   base_x_i,
  input  logic signed [POS_WIDTH-1:0]   base_y_i,
  input  logic signed [POS_WIDTH-1:0]   base_z_i,
  input  logic signed [ANGLE_WIDTH-1:0] base_yaw_i,
  input  logic signed [POS_WIDTH-1:0]   other_x_i,
  input  logic signed [POS_WIDTH-1:0]   other_y_i,
  input  logic signed [POS_WIDTH-1:0]   other_z_i,
  input  logic signed [ANGLE_WIDTH-1:0] other_yaw_i,
  output logic signed [VEC_W-1:0]       vec_x_o,
  output logic signed [VEC_W-1:0]       vec_y_o,
  output logic signed [ANGLE_WIDTH-1:0] ang_o,
  output sb_t                           sb_o
);

  logic signed [VEC_W-1:0]       bx_e, by_e, bz_e, ox_e, oy_e, oz_e;
  logic signed [VEC_W-1:0]       dx, dy;
  logic signed [YAW_EXT_W-1:0]   byaw_e, oyaw_e;
  logic signed [VEC_W-1:0]       vec_x_d, vec_y_d, vec_x_q, vec_y_q;
  logic signed [ANGLE_WIDTH-1:0] ang_d, ang_q;
  sb_t                           sb_d, sb_q;

  assign bx_e   = {base_x_i[POS_WIDTH-1], base_x_i};
  assign by_e   = {base_y_i[POS_WIDTH-1], base_y_i};
  assign bz_e   = {base_z_i[POS_WIDTH-1], base_z_i};
  assign ox_e   = {other_x_i[POS_WIDTH-1], other_x_i};
  assign oy_e   = {other_y_i[POS_WIDTH-1], other_y_i};
  assign oz_e   = {other_z_i[POS_WIDTH-1], other_z_i};
  assign dx     = bx_e - ox_e;
  assign dy     = by_e - oy_e;
  assign byaw_e = {{2{base_yaw_i[ANGLE_WIDTH-1]}}, base_yaw_i};
  assign oyaw_e = {{2{other_yaw_i[ANGLE_WIDTH-1]}}, other_yaw_i};

  always_comb begin
    vec_x_d    = dx;
    vec_y_d    = dy;
    ang_d      = '0;
    sb_d.use_rot = 1'b0;
    sb_d.add_x = dx;
    sb_d.add_y = dy;
    sb_d.z     = bz_e - oz_e;
    sb_d.yaw   = wrap_yaw(byaw_e - oyaw_e);
    unique case (cmd_e'(command_i))
      CMD_COMPOSE: begin
        vec_x_d      = ox_e;
        vec_y_d      = oy_e;
        ang_d        = wrap_yaw(byaw_e);
        sb_d.use_rot = 1'b1;
        sb_d.add_x   = bx_e;
        sb_d.add_y   = by_e;
        sb_d.z       = bz_e + oz_e;
        sb_d.yaw     = wrap_yaw(byaw_e + oyaw_e);
      end
      CMD_RELATIVE: begin
        ang_d        = wrap_yaw(-oyaw_e);
        sb_d.use_rot = 1'b1;
        sb_d.add_x   = '0;
        sb_d.add_y   = '0;
      end
      // plain difference, also the unused code
      default: begin
        sb_d.use_rot = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_x_q <= vec_x_d;
      vec_y_q <= vec_y_d;
      ang_q   <= ang_d;
      sb_q    <= sb_d;
    end
  end

  assign vec_x_o = vec_x_q;
  assign vec_y_o = vec_y_q;
  assign ang_o   = ang_q;
  assign sb_o    = sb_q;

endmodule

>>> hdl/ppc_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_cordic: pipelined rotator
// quarter-turn pre-rotation stage, then one register stage per micro-rotation
// ----------------------------------------------------------------------------
module ppc_cordic import ppc_pkg::*; (
  input  logic                          clk_i,
  input  logic [CORDIC_STAGES:0]        en_i,
  input  logic signed [VEC_W-1:0]       vec_x_i,
  input  logic signed [VEC_W-1:0]       vec_y_i,
  input  logic signed [ANGLE_WIDTH-1:0] ang_i,
  output logic signed [XW-1:0]          x_o,
  output logic signed [XW-1:0]          y_o
);

  localparam logic signed [ZW-1:0] HALF_Z = ZW'(HALF_PI_RAD30);

  logic signed [XW-1:0] x_q [CORDIC_STAGES+1];
  logic signed [XW-1:0] y_q [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_q [CORDIC_STAGES];

  logic signed [XW-1:0] gx, gy, x0_d, y0_d;
  logic signed [ZW-1:0] a0, z0_d;

  assign gx = {{(XW-VEC_W-GUARD_BITS){vec_x_i[VEC_W-1]}}, vec_x_i, {GUARD_BITS{1'b0}}};
  assign gy = {{(XW-VEC_W-GUARD_BITS){vec_y_i[VEC_W-1]}}, vec_y_i, {GUARD_BITS{1'b0}}};
  assign a0 = {{(ZW-ANGLE_WIDTH-ZSHIFT){ang_i[ANGLE_WIDTH-1]}}, ang_i, {ZSHIFT{1'b0}}};

  // bring the angle into [-pi/2, pi/2]
  always_comb begin
    priority if (a0 > HALF_Z) begin
      x0_d = -gy;
      y0_d = gx;
      z0_d = a0 - HALF_Z;
    end else if (a0 < -HALF_Z) begin
      x0_d = gy;
      y0_d = -gx;
      z0_d = a0 + HALF_Z;
    end else begin
      x0_d = gx;
      y0_d = gy;
      z0_d = a0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x_q[0] <= x0_d;
      y_q[0] <= y0_d;
      z_q[0] <= z0_d;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [XW-1:0] xs, ys, x_d, y_d;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_comb begin
      if (!z_q[i][ZW-1]) begin
        x_d = x_q[i] - ys;
        y_d = y_q[i] + xs;
      end else begin
        x_d = x_q[i] + ys;
        y_d = y_q[i] - xs;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[i+1]) begin
        x_q[i+1] <= x_d;
        y_q[i+1] <= y_d;
      end
    end

    // the last stage has no further use for the angle
    if (i < CORDIC_STAGES - 1) begin : g_angle
      logic signed [ZW-1:0] at, z_d;
      assign at = $signed({{(ZW-32){1'b0}}, ATAN_TAB[i]});
      assign z_d = z_q[i][ZW-1] ? z_q[i] + at : z_q[i] - at;
      always_ff @(posedge clk_i) begin
        if (en_i[i+1]) begin
          z_q[i+1] <= z_d;
        end
      end
    end
  end

  assign x_o = x_q[CORDIC_STAGES];
  assign y_o = y_q[CORDIC_STAGES];

endmodule

>>> hdl/ppc_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_gain: cordic gain correction
// magnitude, split constant multiply, round half away from zero, restore sign
// ----------------------------------------------------------------------------
module ppc_gain import ppc_pkg::*; (
  input  logic                 clk_i,
  input  logic [2:0]           en_i,
  input  logic signed [XW-1:0] v_i,
  output logic signed [RW-1:0] r_o
);

  localparam int PLO_W = LO_W + INV_W;
  localparam int PHI_W = XW - LO_W + INV_W;

  logic             neg_d, neg1_q, neg2_q;
  logic [XW-1:0]    mag_d, mag_q;
  logic [PLO_W-1:0] plo_d, plo_q;
  logic [PHI_W-1:0] phi_d, phi_q;
  logic [SUM_W-1:0] sum;
  logic [RW-1:0]    rmag;
  logic signed [RW-1:0] r_d, r_q;

  // stage 1: magnitude
  assign neg_d = v_i[XW-1];
  assign mag_d = neg_d ? XW'(-v_i) : v_i;

  // stage 2: partial products
  assign plo_d = PLO_W'(mag_q[LO_W-1:0]) * PLO_W'(INV_GAIN);
  assign phi_d = PHI_W'(mag_q[XW-1:LO_W]) * PHI_W'(INV_GAIN);

  // stage 3: combine, round and scale back
  assign sum  = (SUM_W'(phi_q) << LO_W) + SUM_W'(plo_q)
              + (SUM_W'(1) << (GAIN_SHIFT - 1));
  assign rmag = RW'(sum >> GAIN_SHIFT);
  assign r_d  = neg2_q ? -$signed(rmag) : $signed(rmag);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      neg1_q <= neg_d;
      mag_q  <= mag_d;
    end
    if (en_i[1]) begin
      neg2_q <= neg1_q;
      plo_q  <= plo_d;
      phi_q  <= phi_d;
    end
    if (en_i[2]) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

>>> hdl/planar_pose_compose.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_pose_compose: planar pose arithmetic
// compose, relative pose and componentwise difference on (x, y, z, yaw) poses,
// q16.16 positions with saturation, q3.13 headings wrapped into (-pi, pi]
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// -------   ---------  ------------------------  ---------------------------------
// in        request    in_valid_i / in_stall_o    command, base pose, other pose
// out       result     out_valid_o / out_stall_i  out_x/y/z, out_yaw, saturated
//
// one request a cycle sustained while the output is not stalled
// reset clears the per-stage valid bits only; the datapath registers are not reset
// each stage advances when it is empty or the one after it moves, so bubbles
// close up under an output stall and input keeps flowing until the pipe is full
//
module planar_pose_compose import ppc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic signed [POS_WIDTH-1:0]   base_x_i,
  input  logic signed [POS_WIDTH-1:0]   base_y_i,
  input  logic signed [POS_WIDTH-1:0]   base_z_i,
  input  logic signed [ANGLE_WIDTH-1:0] base_yaw_i,
  input  logic signed [POS_WIDTH-1:0]   other_x_i,
  input  logic signed [POS_WIDTH-1:0]   other_y_i,
  input  logic signed [POS_WIDTH-1:0]   other_z_i,
  input  logic signed [ANGLE_WIDTH-1:0] other_yaw_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [POS_WIDTH-1:0]   out_x_o,
  output logic signed [POS_WIDTH-1:0]   out_y_o,
  output logic signed [POS_WIDTH-1:0]   out_z_o,
  output logic signed [ANGLE_WIDTH-1:0] out_yaw_o,
  output logic                          saturated_o
);

  // stage map: 0 decode, 1 pre-rotation, 2..CS+1 micro-rotations,
  // CS+2..CS+4 gain correction, CS+5 output register
  localparam int NST   = CORDIC_STAGES + 6;
  localparam int G_ST  = CORDIC_STAGES + 2;
  localparam int SB_N  = CORDIC_STAGES + 4;

  logic [NST-1:0] valid_q, valid_d;
  logic [NST:0]   en;

  // stage enables ripple back from the consumer
  assign en[NST] = !out_stall_i;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !valid_q[k] || en[k+1];
  end

  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NST; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o = !en[0];

  // decode
  logic signed [VEC_W-1:0]       vec_x, vec_y;
  logic signed [ANGLE_WIDTH-1:0] ang;
  sb_t                           sb0;

  ppc_prep u_prep (
    .clk_i       (clk_i),
    .en_i        (en[0]),
    .command_i   (command_i),
    .base_x_i    (base_x_i),
    .base_y_i    (base_y_i),
    .base_z_i    (base_z_i),
    .base_yaw_i  (base_yaw_i),
    .other_x_i   (other_x_i),
    .other_y_i   (other_y_i),
    .other_z_i   (other_z_i),
    .other_yaw_i (other_yaw_i),
    .vec_x_o     (vec_x),
    .vec_y_o     (vec_y),
    .ang_o       (ang),
    .sb_o        (sb0)
  );

  // rotator
  logic signed [XW-1:0] cx, cy;

  ppc_cordic u_cordic (
    .clk_i   (clk_i),
    .en_i    (en[CORDIC_STAGES+1:1]),
    .vec_x_i (vec_x),
    .vec_y_i (vec_y),
    .ang_i   (ang),
    .x_o     (cx),
    .y_o     (cy)
  );

  // gain correction, one per axis
  logic signed [RW-1:0] rot_x, rot_y;

  ppc_gain u_gain_x (
    .clk_i (clk_i),
    .en_i  (en[G_ST+2:G_ST]),
    .v_i   (cx),
    .r_o   (rot_x)
  );

  ppc_gain u_gain_y (
    .clk_i (clk_i),
    .en_i  (en[G_ST+2:G_ST]),
    .v_i   (cy),
    .r_o   (rot_y)
  );

  // sideband travels beside the rotator, entry k-1 belongs to stage k
  sb_t sb_dly_q [SB_N];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sb_dly_q[0] <= sb0;
    end
    for (int k = 1; k < SB_N; k++) begin
      if (en[k+1]) begin
        sb_dly_q[k] <= sb_dly_q[k-1];
      end
    end
  end

  // final add and clip
  sb_t                    sb_f;
  logic signed [FW-1:0]   fx, fy, fz;
  logic [POS_WIDTH:0]     sx, sy, sz;
  logic [POS_WIDTH-1:0]   out_x_q, out_y_q, out_z_q;
  logic [ANGLE_WIDTH-1:0] out_yaw_q;
  logic                   sat_q;

  assign sb_f = sb_dly_q[SB_N-1];

  assign fx = (sb_f.use_rot ? {rot_x[RW-1], rot_x} : FW'(0))
            + {{(FW-VEC_W){sb_f.add_x[VEC_W-1]}}, sb_f.add_x};
  assign fy = (sb_f.use_rot ? {rot_y[RW-1], rot_y} : FW'(0))
            + {{(FW-VEC_W){sb_f.add_y[VEC_W-1]}}, sb_f.add_y};
  assign fz = {{(FW-VEC_W){sb_f.z[VEC_W-1]}}, sb_f.z};

  assign sx = sat_pos(fx);
  assign sy = sat_pos(fy);
  assign sz = sat_pos(fz);

  always_ff @(posedge clk_i) begin
    if (en[NST-1]) begin
      out_x_q   <= sx[POS_WIDTH-1:0];
      out_y_q   <= sy[POS_WIDTH-1:0];
      out_z_q   <= sz[POS_WIDTH-1:0];
      out_yaw_q <= sb_f.yaw;
      sat_q     <= sx[POS_WIDTH] | sy[POS_WIDTH] | sz[POS_WIDTH];
    end
  end

  assign out_valid_o = valid_q[NST-1];
  assign out_x_o     = $signed(out_x_q);
  assign out_y_o     = $signed(out_y_q);
  assign out_z_o     = $signed(out_z_q);
  assign out_yaw_o   = $signed(out_yaw_q);
  assign saturated_o = sat_q;

  // checks
  localparam logic signed [ANGLE_WIDTH:0] PI_Y = (ANGLE_WIDTH + 1)'(PI_Q);

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // a free consumer never blocks the producer
  assert property (@(posedge clk_i) disable iff (!rst_ni) !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");

  // requests in flight change only by accepts on either side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni |=> $countones(valid_q) ==
               $past($countones(valid_q)) + $past(int'(in_acc)) - $past(int'(out_acc)))
    else $error("request lost or duplicated in pipeline");

  // heading result stays wrapped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed({out_yaw_o[ANGLE_WIDTH-1], out_yaw_o}) > -PI_Y) &&
                    ($signed({out_yaw_o[ANGLE_WIDTH-1], out_yaw_o}) <= PI_Y))
    else $error("result heading outside (-pi, pi]");

endmodule

>>> tb/planar_pose_compose_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_pose_compose_tb: self-checking bench for the planar pose unit
// a short table of hand-picked poses, then about a thousand random requests,
// with bursty input and a receiver that stalls on its own pattern; each result
// is checked field by field against a typed pose or a behavioural cordic model
// ----------------------------------------------------------------------------
module planar_pose_compose_tb;
  import ppc_pkg::*;

  localparam int  RANDOM_ITEMS = 1030;
  localparam int  CYCLE_LIMIT  = 400_000;
  // idle after the queue drains to catch stray results (pipeline depth is 22)
  localparam int  DRAIN_CYCLES = 30;
  localparam int  MAX_REPORTS  = 10;

  // unused command code, behaves as the componentwise difference
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // fixed-point constants of the datapath
  localparam longint          HEADING_PI   = 25736;       // pi in q3.13
  localparam longint          HALF_PI_R30  = 1686629713;  // pi/2 in 2^-30 rad
  localparam int              HEADING_SHL  = 17;          // q3.13 to 2^-30 rad
  localparam int              GUARD_SHL    = 8;
  localparam longint unsigned INV_GAIN_Q30 = 64'd652032874;
  localparam longint          POS_MAX      = 64'sd2147483647;
  localparam longint          POS_MIN      = -64'sd2147483648;
  localparam int              ROT_STAGES   = 16;

  // atan(2^-i) in 2^-30 rad, truncated
  localparam longint ARCTAN_R30 [ROT_STAGES] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
  };

  typedef struct {
    logic [1:0]                    command;
    logic signed [POS_WIDTH-1:0]   base_x;
    logic signed [POS_WIDTH-1:0]   base_y;
    logic signed [POS_WIDTH-1:0]   base_z;
    logic signed [ANGLE_WIDTH-1:0] base_yaw;
    logic signed [POS_WIDTH-1:0]   other_x;
    logic signed [POS_WIDTH-1:0]   other_y;
    logic signed [POS_WIDTH-1:0]   other_z;
    logic signed [ANGLE_WIDTH-1:0] other_yaw;
  } pose_req_t;

  typedef struct {
    logic signed [POS_WIDTH-1:0]   x;
    logic signed [POS_WIDTH-1:0]   y;
    logic signed [POS_WIDTH-1:0]   z;
    logic signed [ANGLE_WIDTH-1:0] yaw;
    logic                          sat;
  } pose_res_t;

  typedef struct {
    pose_req_t req;
    bit        known;   // expected pose typed into the table
    pose_res_t want;
  } pose_row_t;

  typedef struct {
    longint x;
    longint y;
  } planar_vec_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [1:0]                    command_i;
  logic signed [POS_WIDTH-1:0]   base_x_i;
  logic signed [POS_WIDTH-1:0]   base_y_i;
  logic signed [POS_WIDTH-1:0]   base_z_i;
  logic signed [ANGLE_WIDTH-1:0] base_yaw_i;
  logic signed [POS_WIDTH-1:0]   other_x_i;
  logic signed [POS_WIDTH-1:0]   other_y_i;
  logic signed [POS_WIDTH-1:0]   other_z_i;
  logic signed [ANGLE_WIDTH-1:0] other_yaw_i;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [POS_WIDTH-1:0]   out_x_o;
  logic signed [POS_WIDTH-1:0]   out_y_o;
  logic signed [POS_WIDTH-1:0]   out_z_o;
  logic signed [ANGLE_WIDTH-1:0] out_yaw_o;
  logic                          saturated_o;

  // poses predicted for accepted requests, oldest first
  pose_res_t awaited_poses [$];
  pose_row_t pose_table [$];
  int        fail_count  = 0;
  int        cycle_count = 0;

  // receiver stall pattern state
  int        stall_mode  = 0;
  int        mode_left   = 0;

  planar_pose_compose dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .base_x_i    (base_x_i),
    .base_y_i    (base_y_i),
    .base_z_i    (base_z_i),
    .base_yaw_i  (base_yaw_i),
    .other_x_i   (other_x_i),
    .other_y_i   (other_y_i),
    .other_z_i   (other_z_i),
    .other_yaw_i (other_yaw_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .out_yaw_o   (out_yaw_o),
    .saturated_o (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // behavioural model of the datapath
  // ---------------------------------------------------------------------------

  // a single 2pi correction into (-pi, pi]
  function automatic longint wrap_heading(input longint a);
    if (a <= -HEADING_PI) return a + 2 * HEADING_PI;
    if (a > HEADING_PI) return a - 2 * HEADING_PI;
    return a;
  endfunction

  // (v * inverse gain) / 2^38, rounded half away from zero
  function automatic longint gain_round(input longint v);
    longint unsigned mag;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned t;
    longint unsigned r;
    mag = (v < 0) ? -v : v;
    hi  = mag >> 32;
    lo  = mag & 64'hFFFF_FFFF;
    t   = lo * INV_GAIN_Q30 + (64'd1 << 37);
    r   = (hi * INV_GAIN_Q30 + (t >> 32)) >> 6;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  // rotate (vx, vy) by a q3.13 heading: quarter-turn pre-rotation, then cordic
  function automatic planar_vec_t turn_vector(input longint vx, input longint vy,
                                              input longint heading);
    longint      x;
    longint      y;
    longint      z;
    longint      t;
    longint      xs;
    longint      ys;
    planar_vec_t r;
    z = wrap_heading(heading) * (longint'(1) << HEADING_SHL);
    x = vx * (longint'(1) << GUARD_SHL);
    y = vy * (longint'(1) << GUARD_SHL);
    if (z > HALF_PI_R30) begin
      t = x; x = -y; y = t; z = z - HALF_PI_R30;
    end else if (z < -HALF_PI_R30) begin
      t = x; x = y; y = -t; z = z + HALF_PI_R30;
    end
    for (int i = 0; i < ROT_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ARCTAN_R30[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ARCTAN_R30[i];
      end
    end
    r.x = gain_round(x);
    r.y = gain_round(y);
    return r;
  endfunction

  function automatic longint clip_pos(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic pose_res_t predict_pose(input pose_req_t r);
    longint      bx;
    longint      by;
    longint      bz;
    longint      byaw;
    longint      ox;
    longint      oy;
    longint      oz;
    longint      oyaw;
    longint      rx;
    longint      ry;
    longint      rz;
    longint      ryaw;
    longint      cx;
    longint      cy;
    longint      cz;
    planar_vec_t v;
    pose_res_t   p;
    bx = r.base_x;  by = r.base_y;  bz = r.base_z;  byaw = r.base_yaw;
    ox = r.other_x; oy = r.other_y; oz = r.other_z; oyaw = r.other_yaw;
    case (r.command)
      CMD_COMPOSE: begin
        v    = turn_vector(ox, oy, byaw);
        rx   = v.x + bx;
        ry   = v.y + by;
        rz   = bz + oz;
        ryaw = wrap_heading(byaw + oyaw);
      end
      CMD_RELATIVE: begin
        v    = turn_vector(bx - ox, by - oy, -oyaw);
        rx   = v.x;
        ry   = v.y;
        rz   = bz - oz;
        ryaw = wrap_heading(byaw - oyaw);
      end
      default: begin
        // difference, and the spare code with it
        rx   = bx - ox;
        ry   = by - oy;
        rz   = bz - oz;
        ryaw = wrap_heading(byaw - oyaw);
      end
    endcase
    cx = clip_pos(rx);
    cy = clip_pos(ry);
    cz = clip_pos(rz);
    p.x   = cx[POS_WIDTH-1:0];
    p.y   = cy[POS_WIDTH-1:0];
    p.z   = cz[POS_WIDTH-1:0];
    p.yaw = ryaw[ANGLE_WIDTH-1:0];
    p.sat = (cx != rx) || (cy != ry) || (cz != rz);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // random request generation
  // ---------------------------------------------------------------------------

  // mostly small and medium distances, with full-range words and extremes
  function automatic logic [POS_WIDTH-1:0] random_pos();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      5, 6:          return $urandom;
      7:             return int'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
      default: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // headings mostly within (-pi, pi], sometimes any bit pattern or a boundary
  function automatic logic [ANGLE_WIDTH-1:0] random_heading();
    int h;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: h = int'($urandom_range(0, 51471)) - 25735;
      6:                h = int'($urandom_range(0, 200)) - 100;
      7:                h = $urandom;
      default: begin
        case ($urandom_range(0, 7))
          0:       h = 25736;
          1:       h = -25735;
          2:       h = -25736;
          3:       h = 12868;
          4:       h = -12868;
          5:       h = 0;
          6:       h = 32767;
          default: h = -32768;
        endcase
      end
    endcase
    return h[ANGLE_WIDTH-1:0];
  endfunction

  function automatic pose_req_t random_request();
    pose_req_t r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r.command = CMD_COMPOSE;
      4, 5, 6:    r.command = CMD_RELATIVE;
      7, 8:       r.command = CMD_DIFF;
      default:    r.command = CMD_SPARE;
    endcase
    r.base_x    = random_pos();
    r.base_y    = random_pos();
    r.base_z    = random_pos();
    r.base_yaw  = random_heading();
    r.other_x   = random_pos();
    r.other_y   = random_pos();
    r.other_z   = random_pos();
    r.other_yaw = random_heading();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // one table row; the expected fields matter only when known is set
  task automatic add_row(input logic [1:0] cmd,
                         input logic [31:0] bx, input logic [31:0] by,
                         input logic [31:0] bz, input logic [15:0] byaw,
                         input logic [31:0] ox, input logic [31:0] oy,
                         input logic [31:0] oz, input logic [15:0] oyaw,
                         input bit known,
                         input logic [31:0] ex, input logic [31:0] ey,
                         input logic [31:0] ez, input logic [15:0] eyaw,
                         input logic esat);
    pose_row_t row;
    row.req.command   = cmd;
    row.req.base_x    = bx;
    row.req.base_y    = by;
    row.req.base_z    = bz;
    row.req.base_yaw  = byaw;
    row.req.other_x   = ox;
    row.req.other_y   = oy;
    row.req.other_z   = oz;
    row.req.other_yaw = oyaw;
    row.known         = known;
    row.want.x        = ex;
    row.want.y        = ey;
    row.want.z        = ez;
    row.want.yaw      = eyaw;
    row.want.sat      = esat;
    pose_table.push_back(row);
  endtask

  // present a request at the falling edge and hold it until accepted
  task automatic send_request(input pose_req_t r, input pose_res_t want);
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    command_i   <= r.command;
    base_x_i    <= r.base_x;
    base_y_i    <= r.base_y;
    base_z_i    <= r.base_z;
    base_yaw_i  <= r.base_yaw;
    other_x_i   <= r.other_x;
    other_y_i   <= r.other_y;
    other_z_i   <= r.other_z;
    other_yaw_i <= r.other_yaw;
    do @(posedge clk_i); while (in_stall_o);
    awaited_poses.push_back(want);
  endtask

  // drop valid and idle before the next request, n sets the gap length
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    idle_cycles(1);
    while (awaited_poses.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver stall pattern: free flow, light random, heavy random or alternating,
  // each held for a random stretch of cycles
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 150);
    end else begin
      mode_left  <= mode_left - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 9) < 7);
      default: out_stall_i <= ~out_stall_i;
    endcase
  end

  // compare each delivered pose with the oldest prediction
  always @(posedge clk_i) begin : check_results
    pose_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_poses.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected pose: x=%h y=%h z=%h yaw=%h sat=%b",
                   out_x_o, out_y_o, out_z_o, out_yaw_o, saturated_o);
      end else begin
        want = awaited_poses.pop_front();
        if (out_x_o !== want.x || out_y_o !== want.y || out_z_o !== want.z ||
            out_yaw_o !== want.yaw || saturated_o !== want.sat) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("pose mismatch: exp x=%h y=%h z=%h yaw=%h sat=%b",
                     want.x, want.y, want.z, want.yaw, want.sat);
            $display("               got x=%h y=%h z=%h yaw=%h sat=%b",
                     out_x_o, out_y_o, out_z_o, out_yaw_o, saturated_o);
          end
        end
      end
    end
  end

  // hard stop for a hung handshake
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("planar_pose_compose test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int        burst_left;
    int        gap;
    pose_req_t req;
    pose_res_t want;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    command_i   = CMD_COMPOSE;
    base_x_i    = '0;
    base_y_i    = '0;
    base_z_i    = '0;
    base_yaw_i  = '0;
    other_x_i   = '0;
    other_y_i   = '0;
    other_z_i   = '0;
    other_yaw_i = '0;
    burst_left  = 0;

    // rows with typed results: all-zero, opposite extremes, the spare code,
    // out-of-range headings that one 2pi correction must bring back
    add_row(CMD_DIFF, 32'h0, 32'h0, 32'h0, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0,
            1, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0);
    add_row(CMD_DIFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'h6488,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h9B79,
            1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'hFFFF, 1'b1);
    // zero heading and zero offset: rotation contributes nothing, z clips high
    add_row(CMD_COMPOSE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0,
            32'h0, 32'h0, 32'h1, 16'h6488,
            1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h6488, 1'b1);
    add_row(CMD_SPARE, 32'h0001_0000, 32'h0, 32'h0, 16'h9B79,
            32'h0000_8000, 32'h0001_0000, 32'h0, 16'h0001,
            1, 32'h0000_8000, 32'hFFFF_0000, 32'h0, 16'h6488, 1'b0);
    add_row(CMD_DIFF, 32'h0, 32'h0, 32'h8000_0000, 16'h8000,
            32'h0, 32'h0, 32'h7FFF_FFFF, 16'h7FFF,
            1, 32'h0, 32'h0, 32'h8000_0000, 16'hC911, 1'b1);
    add_row(CMD_DIFF, 32'h0, 32'h0, 32'h0, 16'h7FFF, 32'h0, 32'h0, 32'h0, 16'h8000,
            1, 32'h0, 32'h0, 32'h0, 16'h36EF, 1'b0);
    add_row(CMD_RELATIVE, 32'h0, 32'h0, 32'h0, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0,
            1, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0);

    // rows checked by the model: half turns, quarter-turn boundaries,
    // rotation of huge vectors into saturation, out-of-range rotation angles
    add_row(CMD_COMPOSE, 32'h0, 32'h0, 32'h0, 16'h6488,
            32'h0001_0000, 32'h0, 32'h0, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_COMPOSE, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 16'h9B79,
            32'h0001_0000, 32'h0002_0000, 32'h0, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_COMPOSE, 32'h0, 32'h0, 32'h0, 16'h3244,
            32'h0001_0000, 32'h0001_0000, 32'h0, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_COMPOSE, 32'h0, 32'h0, 32'h0, 16'hCDBC,
            32'h0001_0000, 32'hFFFF_0000, 32'h0, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_COMPOSE, 32'h0, 32'h0, 32'h0, 16'h3243,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_COMPOSE, 32'h0, 32'h0, 32'h0, 16'h1922,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_COMPOSE, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 16'h7FFF,
            32'h0003_0000, 32'hFFFD_0000, 32'h0, 16'h7FFF, 0, 0, 0, 0, 0, 0);
    add_row(CMD_COMPOSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 0, 0, 0, 0, 0, 0);
    add_row(CMD_COMPOSE, 32'h0, 32'h0, 32'h0, 16'h0,
            32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 16'h0001, 0, 0, 0, 0, 0, 0);
    add_row(CMD_RELATIVE, 32'h0005_0000, 32'h0003_0000, 32'h0001_0000, 16'h0,
            32'h0001_0000, 32'h0001_0000, 32'h0, 16'h1922, 0, 0, 0, 0, 0, 0);
    // minus the most negative heading pattern lands outside the range
    add_row(CMD_RELATIVE, 32'h0, 32'h0, 32'h0, 16'h0,
            32'hFFFF_0000, 32'h0002_0000, 32'h0, 16'h8000, 0, 0, 0, 0, 0, 0);
    // translation difference needs the extra bit through the rotator
    add_row(CMD_RELATIVE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'h0,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_RELATIVE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h6488,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h9B79, 0, 0, 0, 0, 0, 0);
    add_row(CMD_RELATIVE, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 16'h9B79,
            32'h0, 32'h0, 32'h0, 16'h6488, 0, 0, 0, 0, 0, 0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table, mostly back to back
    foreach (pose_table[i]) begin
      want = pose_table[i].known ? pose_table[i].want : predict_pose(pose_table[i].req);
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 3));
      send_request(pose_table[i].req, want);
    end

    // random requests in bursts with gaps; once midway the sender holds
    // off until the pipe has emptied
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        idle_cycles(gap);
      end
      burst_left--;
      if (n == RANDOM_ITEMS / 2) drain_results();
      req = random_request();
      send_request(req, predict_pose(req));
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("planar_pose_compose test passed");
    end else begin
      $display("planar_pose_compose test failed");
    end
    $finish;
  end

endmodule
